FILE: rtl/core/ttc_pkg.sv
// ---------------------------------------------------------------------------
// Tap click recogniser package
// Shared types, codes and reset values of the tap click recogniser.
// ---------------------------------------------------------------------------
package ttc_pkg;

  // Item kinds.
  localparam logic [1:0] KIND_CONTACT = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_INVAL   = 2'd2;
  localparam logic [1:0] KIND_CLEAR   = 2'd3;

  // Click actions.
  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_LEFT   = 2'd1;
  localparam logic [1:0] ACT_RIGHT  = 2'd2;
  localparam logic [1:0] ACT_MIDDLE = 2'd3;

  // Configuration register indices.
  localparam logic [1:0] CFG_MAX_DUR  = 2'd0;
  localparam logic [1:0] CFG_MAX_MOVE = 2'd1;
  localparam logic [1:0] CFG_SPLIT_X  = 2'd2;

  // Touch counts that lead to a click, and the largest acceptable count.
  localparam logic [3:0] ONE_TOUCH   = 4'd1;
  localparam logic [3:0] THREE_TOUCH = 4'd3;
  localparam logic [3:0] MAX_TOUCHES = 4'd3;

  // Register values after reset (0.28 s, 0.04 and 0.5 of the surface).
  localparam logic [31:0] RST_MAX_DUR  = 32'd280000;
  localparam logic [15:0] RST_MAX_MOVE = 16'd2621;
  localparam logic [31:0] RST_LIM_SQ   = 32'(RST_MAX_MOVE) * 32'(RST_MAX_MOVE);
  localparam logic [15:0] RST_SPLIT_X  = 16'd32768;

  // One input transaction as held in the input register.
  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  touch_count;
    logic [31:0] contact_id;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [31:0] time_us;
    logic        conflicting;
  } item_t;

  // Configuration as seen by the tracker.
  typedef struct packed {
    logic [31:0] max_dur;
    logic [31:0] lim_sq;
    logic [15:0] split_x;
  } cfg_t;

  // One result.
  typedef struct packed {
    logic [1:0] action;
    logic       is_tracking;
  } res_t;

endpackage

FILE: rtl/core/ttc_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module ttc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/ttc_cfg.sv
// ---------------------------------------------------------------------------
// Tap click recogniser configuration
// Configuration registers; the movement limit is kept squared.
// ---------------------------------------------------------------------------
module ttc_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output ttc_pkg::cfg_t     cfg
);

  logic [31:0] max_dur;
  logic [31:0] lim_sq;
  logic [15:0] split_x;

  // Register writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_dur <= ttc_pkg::RST_MAX_DUR;
      lim_sq  <= ttc_pkg::RST_LIM_SQ;
      split_x <= ttc_pkg::RST_SPLIT_X;
    end else if (cfg_we) begin
      case (cfg_index)
        ttc_pkg::CFG_MAX_DUR:  max_dur <= cfg_data;
        ttc_pkg::CFG_MAX_MOVE: lim_sq  <= 32'(cfg_data[15:0]) * 32'(cfg_data[15:0]);
        ttc_pkg::CFG_SPLIT_X:  split_x <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign cfg.max_dur = max_dur;
  assign cfg.lim_sq  = lim_sq;
  assign cfg.split_x = split_x;

endmodule

FILE: rtl/core/ttc_track.sv
// ---------------------------------------------------------------------------
// Tap click recogniser tracker
// Gesture state, per-contact origins and the click decision.
// ---------------------------------------------------------------------------
module ttc_track #(
  parameter int ID_SLOTS = 16,
  localparam int SW = $clog2(ID_SLOTS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              look_en,
  input  logic [SW-1:0]     look_slot,
  input  logic              proc,
  input  ttc_pkg::item_t    item,
  input  ttc_pkg::cfg_t     cfg,
  output ttc_pkg::res_t     res
);

  // Gesture state.
  logic                tracking, tracking_next;
  logic                invalid_flag, invalid_flag_next;
  logic [31:0]         start_time, start_time_next;
  logic [15:0]         first_x, first_x_next;
  logic [3:0]          peak_touches, peak_touches_next;
  logic [ID_SLOTS-1:0] slot_seen, slot_seen_next;

  // Movement check carried into the following cycle.
  logic                mv_pend, mv_pend_next;
  logic [15:0]         mv_dx, mv_dy;

  // Origin store and read bypass.
  logic                ram_we;
  logic [31:0]         ram_wdata, ram_rdata;
  logic                byp_hit;
  logic [31:0]         byp_data;
  logic [15:0]         org_x, org_y;

  logic [SW-1:0]       slot;
  logic                id_ok, seen;
  logic [31:0]         elapsed;
  logic                late, count_bad;
  logic [15:0]         dx_abs, dy_abs;
  logic [31:0]         sq_x, sq_y;
  logic                viol;
  logic                ok;
  logic [1:0]          action;

  assign slot  = item.contact_id[SW-1:0];
  assign id_ok = item.contact_id < 32'(ID_SLOTS);
  assign seen  = slot_seen[slot];

  // The first sighting of a contact stores its position.
  assign ram_we    = proc && (item.kind == ttc_pkg::KIND_CONTACT) && id_ok && !seen;
  assign ram_wdata = {item.pos_x, item.pos_y};

  ttc_ram #(
    .WIDTH (32),
    .DEPTH (ID_SLOTS)
  ) u_origin (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (slot),
    .wr_data (ram_wdata),
    .rd_en   (look_en),
    .rd_addr (look_slot),
    .rd_data (ram_rdata)
  );

  // An origin written in the same cycle as the look-up is taken from the bypass.
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_hit <= 1'b0;
    end else if (look_en) begin
      byp_hit <= ram_we && (slot == look_slot);
    end
  end

  always_ff @(posedge clk) begin
    if (look_en) begin
      byp_data <= ram_wdata;
    end
  end

  assign org_x = byp_hit ? byp_data[31:16] : ram_rdata[31:16];
  assign org_y = byp_hit ? byp_data[15:0]  : ram_rdata[15:0];

  // Time since the gesture began; a new gesture starts at the current time.
  assign elapsed   = item.time_us - (tracking ? start_time : item.time_us);
  assign late      = elapsed > cfg.max_dur;
  assign count_bad = item.touch_count > ttc_pkg::MAX_TOUCHES;

  // Absolute displacement from the stored origin.
  assign dx_abs = (item.pos_x >= org_x) ? item.pos_x - org_x : org_x - item.pos_x;
  assign dy_abs = (item.pos_y >= org_y) ? item.pos_y - org_y : org_y - item.pos_y;

  // Squared distance test of the previous contact, in the cycle after it.
  assign sq_x = 32'(mv_dx) * 32'(mv_dx);
  assign sq_y = 32'(mv_dy) * 32'(mv_dy);
  assign viol = mv_pend && ((33'(sq_x) + 33'(sq_y)) > 33'(cfg.lim_sq));

  // Next state and result of the item being processed.
  always_comb begin
    tracking_next     = tracking;
    invalid_flag_next = invalid_flag | viol;
    start_time_next   = start_time;
    first_x_next      = first_x;
    peak_touches_next = peak_touches;
    slot_seen_next    = slot_seen;
    mv_pend_next      = 1'b0;
    ok                = 1'b0;
    action            = ttc_pkg::ACT_NONE;
    if (proc) begin
      case (item.kind)
        ttc_pkg::KIND_CONTACT: begin
          tracking_next = 1'b1;
          if (!tracking) begin
            start_time_next = item.time_us;
            first_x_next    = item.pos_x;
          end
          if (late || count_bad || item.conflicting || !id_ok) begin
            invalid_flag_next = 1'b1;
          end
          if (item.touch_count > peak_touches) begin
            peak_touches_next = item.touch_count;
          end
          if (id_ok) begin
            if (!seen) begin
              slot_seen_next[slot] = 1'b1;
            end else begin
              mv_pend_next = 1'b1;
            end
          end
        end
        ttc_pkg::KIND_END: begin
          if (tracking) begin
            ok = !(invalid_flag || viol) && !late;
            if (ok && (peak_touches == ttc_pkg::ONE_TOUCH)) begin
              action = (first_x < cfg.split_x) ? ttc_pkg::ACT_LEFT : ttc_pkg::ACT_RIGHT;
            end else if (ok && (peak_touches == ttc_pkg::THREE_TOUCH)) begin
              action = ttc_pkg::ACT_MIDDLE;
            end
            tracking_next     = 1'b0;
            invalid_flag_next = 1'b0;
            start_time_next   = '0;
            first_x_next      = '0;
            peak_touches_next = '0;
            slot_seen_next    = '0;
          end
        end
        ttc_pkg::KIND_INVAL: begin
          if (tracking) begin
            invalid_flag_next = 1'b1;
          end
        end
        default: begin
          tracking_next     = 1'b0;
          invalid_flag_next = 1'b0;
          start_time_next   = '0;
          first_x_next      = '0;
          peak_touches_next = '0;
          slot_seen_next    = '0;
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tracking     <= 1'b0;
      invalid_flag <= 1'b0;
      start_time   <= '0;
      first_x      <= '0;
      peak_touches <= '0;
      slot_seen    <= '0;
      mv_pend      <= 1'b0;
    end else begin
      tracking     <= tracking_next;
      invalid_flag <= invalid_flag_next;
      start_time   <= start_time_next;
      first_x      <= first_x_next;
      peak_touches <= peak_touches_next;
      slot_seen    <= slot_seen_next;
      mv_pend      <= mv_pend_next;
    end
  end

  // Displacement held for the squaring cycle.
  always_ff @(posedge clk) begin
    if (proc) begin
      mv_dx <= dx_abs;
      mv_dy <= dy_abs;
    end
  end

  assign res.action      = action;
  assign res.is_tracking = tracking_next;

  // An idle tracker holds no contact history.
  assert property (@(posedge clk) disable iff (rst)
    !tracking |-> (slot_seen == '0))
    else $error("slot history present while idle");

  // Only a tracked gesture can be invalid or have a touch count.
  assert property (@(posedge clk) disable iff (rst)
    !tracking |-> (!invalid_flag && (peak_touches == '0)))
    else $error("gesture state present while idle");

  // A pending movement check belongs to a tracked gesture.
  assert property (@(posedge clk) disable iff (rst)
    mv_pend |-> tracking)
    else $error("movement check pending while idle");

  // A click is only given for an end transaction that closes the gesture.
  assert property (@(posedge clk) disable iff (rst)
    (action != ttc_pkg::ACT_NONE) |-> (proc && tracking && !tracking_next))
    else $error("click without a closed gesture");

endmodule

FILE: rtl/core/touch_tap_click_recognizer_core.sv
// ---------------------------------------------------------------------------
// Touch tap click recogniser
// Turns per-contact touch transactions into left, right and middle clicks.
// ---------------------------------------------------------------------------
// The block takes one transaction per clock cycle while its input is not
// stalled and returns exactly one result for each. A transaction passes
// through the input register, is decided once the result register can take it
// and lands in the result register, where its result is offered. While a
// result waits in a stalled result register, the input register takes one
// further transaction and then stalls the input until the result is taken.
// The squared movement test of a contact is finished in the cycle after that
// contact and is folded into the invalid state before any later end
// transaction decides. Contact origins live in a small RAM with one entry
// per identifier, read as the transaction enters the input register. The user
// must write configuration only while idle; the block does not enforce it.
module touch_tap_click_recognizer_core #(
  parameter int ID_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // Input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic        first_of_frame,
  input  logic [3:0]  touch_count,
  input  logic [31:0] contact_id,
  input  logic [15:0] pos_x,
  input  logic [15:0] pos_y,
  input  logic [31:0] time_us,
  input  logic        conflicting,
  // Output channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  action,
  output logic        is_tracking
);

  localparam int SW = $clog2(ID_SLOTS);

  logic           in_full;
  ttc_pkg::item_t in_item;
  logic           in_acc;
  logic           out_free;
  logic           proc;
  ttc_pkg::cfg_t  cfg;
  ttc_pkg::res_t  res;

  // Handshake. The frame marker is not stored: the per-frame checks give the
  // same answer however often they repeat within a frame.
  assign out_free = !out_valid || !out_stall;
  assign proc     = in_full && out_free;
  assign in_stall = in_full && !out_free;
  assign in_acc   = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_acc) begin
      in_full <= 1'b1;
    end else if (proc) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_item.kind        <= kind;
      in_item.touch_count <= touch_count;
      in_item.contact_id  <= contact_id;
      in_item.pos_x       <= pos_x;
      in_item.pos_y       <= pos_y;
      in_item.time_us     <= time_us;
      in_item.conflicting <= conflicting;
    end
  end

  ttc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ttc_track #(
    .ID_SLOTS (ID_SLOTS)
  ) u_track (
    .clk       (clk),
    .rst       (rst),
    .look_en   (in_acc),
    .look_slot (contact_id[SW-1:0]),
    .proc      (proc),
    .item      (in_item),
    .cfg       (cfg),
    .res       (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      action      <= res.action;
      is_tracking <= res.is_tracking;
    end
  end

endmodule

FILE: bench/tb_touch_tap_click_recognizer_core.sv
// ---------------------------------------------------------------------------
// Testbench for the touch tap click recogniser core
// A table of directed transactions, then phases of random gestures under
// several register settings and idling patterns. Every result is checked against
// its row's typed result or a cycle-free predictor of the recogniser in this module.
// ---------------------------------------------------------------------------
module tb_touch_tap_click_recognizer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOT_COUNT  = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 200;
  localparam int HOLD_CYCLES = 400;

  // One input transaction as the stimulus sees it.
  typedef struct packed {
    logic [1:0]  kind;
    logic        fof;
    logic [3:0]  cnt;
    logic [31:0] id;
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] t;
    logic        conf;
  } tap_item_t;

  // A directed row: the transaction and, where obvious, its result.
  typedef struct packed {
    tap_item_t     item;
    logic          typed;
    ttc_pkg::res_t res;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  kind;
  logic        first_of_frame;
  logic [3:0]  touch_count;
  logic [31:0] contact_id;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [31:0] time_us;
  logic        conflicting;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  action;
  logic        is_tracking;

  touch_tap_click_recognizer_core #(
    .ID_SLOTS(SLOT_COUNT)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .first_of_frame(first_of_frame),
    .touch_count(touch_count),
    .contact_id(contact_id),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .time_us(time_us),
    .conflicting(conflicting),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .action(action),
    .is_tracking(is_tracking)
  );

  // Predictor copy of the registers and the gesture state.
  logic [31:0] cfg_max_dur;
  logic [15:0] cfg_max_move;
  logic [15:0] cfg_split_x;
  logic        g_tracking;
  logic        g_invalid;
  logic [31:0] g_start;
  logic [15:0] g_first_x;
  logic [3:0]  g_peak;
  logic        g_seen [SLOT_COUNT];
  logic [15:0] g_org_x [SLOT_COUNT];
  logic [15:0] g_org_y [SLOT_COUNT];

  ttc_pkg::res_t click_queue[$];
  dir_row_t      dir_table[$];
  int            error_count;
  int            sent_items;
  int            cycle_count;
  int            tx_idle_pct;
  int            rx_stall_pct;
  bit            hold_req;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("touch_tap_click_recognizer_core: mismatch");
      $finish;
    end
  end

  function automatic dir_row_t drow(input logic [1:0] k, input logic f, input logic [3:0] c,
                                    input logic [31:0] id, input logic [15:0] x,
                                    input logic [15:0] y, input logic [31:0] t,
                                    input logic cf, input logic typed, input logic [1:0] act,
                                    input logic trk);
    dir_row_t r;
    r.item = '{kind: k, fof: f, cnt: c, id: id, x: x, y: y, t: t, conf: cf};
    r.typed = typed;
    r.res.action = act;
    r.res.is_tracking = trk;
    return r;
  endfunction

  function automatic void clear_gesture();
    g_tracking = 1'b0;
    g_invalid  = 1'b0;
    g_start    = '0;
    g_first_x  = '0;
    g_peak     = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      g_seen[i]  = 1'b0;
      g_org_x[i] = '0;
      g_org_y[i] = '0;
    end
  endfunction

  // Works out the click result of one transaction and advances the state.
  function automatic ttc_pkg::res_t recognise_tap(input tap_item_t it);
    logic [31:0]   elapsed;
    longint        dx;
    longint        dy;
    longint        lim;
    logic [3:0]    slot;
    logic          ok;
    logic [3:0]    peak;
    logic [15:0]   fx;
    ttc_pkg::res_t r;
    r.action = ttc_pkg::ACT_NONE;
    case (it.kind)
      ttc_pkg::KIND_CONTACT: begin
        if (!g_tracking) begin
          clear_gesture();
          g_tracking = 1'b1;
          g_start    = it.t;
          g_first_x  = it.x;
        end
        elapsed = it.t - g_start;
        if (elapsed > cfg_max_dur || it.cnt > ttc_pkg::MAX_TOUCHES || it.conf)
          g_invalid = 1'b1;
        if (it.cnt > g_peak) g_peak = it.cnt;
        slot = it.id[3:0];
        if (it.id >= SLOT_COUNT) begin
          g_invalid = 1'b1;
        end else if (!g_seen[slot]) begin
          g_seen[slot]  = 1'b1;
          g_org_x[slot] = it.x;
          g_org_y[slot] = it.y;
        end else begin
          dx  = longint'(it.x) - longint'(g_org_x[slot]);
          dy  = longint'(it.y) - longint'(g_org_y[slot]);
          lim = longint'(cfg_max_move) * longint'(cfg_max_move);
          if (dx * dx + dy * dy > lim) g_invalid = 1'b1;
        end
      end
      ttc_pkg::KIND_END: begin
        if (g_tracking) begin
          elapsed = it.t - g_start;
          ok   = !g_invalid && elapsed <= cfg_max_dur;
          peak = g_peak;
          fx   = g_first_x;
          clear_gesture();
          if (ok) begin
            if (peak == ttc_pkg::ONE_TOUCH)
              r.action = (fx < cfg_split_x) ? ttc_pkg::ACT_LEFT : ttc_pkg::ACT_RIGHT;
            else if (peak == ttc_pkg::THREE_TOUCH)
              r.action = ttc_pkg::ACT_MIDDLE;
          end
        end
      end
      ttc_pkg::KIND_INVAL: begin
        if (g_tracking) g_invalid = 1'b1;
      end
      default: begin
        clear_gesture();
      end
    endcase
    r.is_tracking = g_tracking;
    return r;
  endfunction

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    ttc_pkg::res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (click_queue.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("%0t: result with nothing expected: action %0d tracking %0d",
                   $realtime, action, is_tracking);
      end else begin
        want = click_queue.pop_front();
        if (action !== want.action) begin
          error_count++;
          if (error_count <= 10)
            $display("%0t: action expected %0d got %0d", $realtime, want.action, action);
        end
        if (is_tracking !== want.is_tracking) begin
          error_count++;
          if (error_count <= 10)
            $display("%0t: is_tracking expected %0d got %0d", $realtime,
                     want.is_tracking, is_tracking);
        end
      end
    end
  end

  // Receiver: random stall, and a long hold-off when one is requested.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  // Offers one transaction, waits for its acceptance and records its result.
  // Called and left at a falling edge.
  task automatic send_item(input tap_item_t it, input logic typed,
                           input ttc_pkg::res_t typed_res);
    int            gap;
    ttc_pkg::res_t pred;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    kind           <= it.kind;
    first_of_frame <= it.fof;
    touch_count    <= it.cnt;
    contact_id     <= it.id;
    pos_x          <= it.x;
    pos_y          <= it.y;
    time_us        <= it.t;
    conflicting    <= it.conf;
    in_valid       <= 1'b1;
    do @(posedge clk); while (in_stall);
    pred = recognise_tap(it);
    click_queue.push_back(typed ? typed_res : pred);
    sent_items++;
    @(negedge clk);
  endtask

  // Stops offering and waits until every expected result has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (click_queue.size() != 0);
  endtask

  // Writes all three registers while the block is idle.
  task automatic write_config(input logic [31:0] dur, input logic [31:0] mv,
                              input logic [31:0] sp);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= ttc_pkg::CFG_MAX_DUR;
    cfg_data  <= dur;
    @(negedge clk);
    cfg_index <= ttc_pkg::CFG_MAX_MOVE;
    cfg_data  <= mv;
    @(negedge clk);
    cfg_index <= ttc_pkg::CFG_SPLIT_X;
    cfg_data  <= sp;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_max_dur  = dur;
    cfg_max_move = mv[15:0];
    cfg_split_x  = sp[15:0];
  endtask

  function automatic tap_item_t noise_item();
    tap_item_t it;
    it.kind = 2'($urandom_range(3));
    it.fof  = 1'($urandom);
    it.cnt  = 4'($urandom);
    it.id   = $urandom_range(1) ? $urandom_range(0, 17) : $urandom;
    it.x    = 16'($urandom);
    it.y    = 16'($urandom);
    it.t    = $urandom;
    it.conf = 1'($urandom);
    return it;
  endfunction

  // One gesture: a few frames of contacts, then an end transaction.
  task automatic gen_gesture();
    tap_item_t   it;
    logic [31:0] ids [16];
    logic [15:0] ox [16];
    logic [15:0] oy [16];
    logic [31:0] start;
    longint      span;
    int          n;
    int          frames;
    int          base;
    int          pick;
    int          j;
    int          m;
    int          dx;
    int          dy;
    pick = $urandom_range(99);
    if (pick < 40) n = 1;
    else if (pick < 55) n = 2;
    else if (pick < 90) n = 3;
    else n = $urandom_range(4, 15);
    frames = $urandom_range(1, 4);
    base = $urandom_range(0, 15);
    for (int k = 0; k < n; k++) begin
      ids[k] = (base + k) % SLOT_COUNT;
      ox[k]  = 16'($urandom);
      oy[k]  = 16'($urandom);
    end
    if ($urandom_range(99) < 4)
      ids[$urandom_range(0, n - 1)] = $urandom_range(1) ? $urandom_range(16, 40) : $urandom;
    start = $urandom;
    if ($urandom_range(99) < 80) span = longint'($urandom_range(0, cfg_max_dur));
    else span = longint'(cfg_max_dur) + longint'($urandom_range(1, 1000));
    m = int'(cfg_max_move);
    for (int f = 0; f < frames; f++) begin
      for (int k = 0; k < n; k++) begin
        it = noise_item();
        it.kind = ttc_pkg::KIND_CONTACT;
        it.fof  = (k == 0);
        it.cnt  = 4'(n);
        it.id   = ids[k];
        it.t    = start + 32'((span * f) / frames);
        it.conf = ($urandom_range(99) < 4);
        if (f == 0) begin
          it.x = ox[k];
          it.y = oy[k];
        end else begin
          j  = ($urandom_range(99) < 85) ? m / 2 : m + 1 + int'($urandom_range(0, m + 2));
          dx = int'($urandom_range(0, 2 * j)) - j;
          dy = int'($urandom_range(0, 2 * j)) - j;
          it.x = ox[k] + 16'(dx);
          it.y = oy[k] + 16'(dy);
        end
        send_item(it, 1'b0, '0);
      end
      if ($urandom_range(99) < 5) begin
        it = noise_item();
        it.kind = $urandom_range(1) ? ttc_pkg::KIND_INVAL : ttc_pkg::KIND_CLEAR;
        send_item(it, 1'b0, '0);
      end
    end
    it = noise_item();
    it.kind = ttc_pkg::KIND_END;
    it.t    = start + 32'(span);
    send_item(it, 1'b0, '0);
  endtask

  // One random phase under a register setting and an idling pattern.
  task automatic run_phase(input logic [31:0] dur, input logic [31:0] mv,
                           input logic [31:0] sp, input int tx_pct, input int rx_pct,
                           input bit hold, input bit pause_mid);
    int first;
    bit paused;
    write_config(dur, mv, sp);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    if (hold) hold_req = 1'b1;
    first  = sent_items;
    paused = 1'b0;
    while (sent_items - first < PHASE_ITEMS) begin
      if ($urandom_range(99) < 12) begin
        repeat ($urandom_range(1, 3)) send_item(noise_item(), 1'b0, '0);
      end else begin
        gen_gesture();
      end
      if (pause_mid && !paused && sent_items - first >= PHASE_ITEMS / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end
  endtask

  // Stimulus: reset, directed table, then random phases.
  initial begin
    error_count    = 0;
    sent_items     = 0;
    tx_idle_pct    = 0;
    rx_stall_pct   = 0;
    hold_req       = 1'b0;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = ttc_pkg::CFG_MAX_DUR;
    cfg_data       = '0;
    in_valid       = 1'b0;
    kind           = ttc_pkg::KIND_CONTACT;
    first_of_frame = 1'b0;
    touch_count    = '0;
    contact_id     = '0;
    pos_x          = '0;
    pos_y          = '0;
    time_us        = '0;
    conflicting    = 1'b0;
    cfg_max_dur    = ttc_pkg::RST_MAX_DUR;
    cfg_max_move   = ttc_pkg::RST_MAX_MOVE;
    cfg_split_x    = ttc_pkg::RST_SPLIT_X;
    clear_gesture();

    // Directed rows under the register values after reset.
    dir_table.push_back(drow(ttc_pkg::KIND_END,     0,  0, 0, 0, 0, 0, 0, 1,
                             ttc_pkg::ACT_NONE, 0));
    dir_table.push_back(drow(ttc_pkg::KIND_INVAL,   0,  0, 0, 0, 0, 0, 0, 1,
                             ttc_pkg::ACT_NONE, 0));
    dir_table.push_back(drow(ttc_pkg::KIND_CLEAR,   0,  0, 0, 0, 0, 0, 0, 1,
                             ttc_pkg::ACT_NONE, 0));
    // Single touch that moves exactly the limit and ends at the time limit.
    dir_table.push_back(drow(ttc_pkg::KIND_CONTACT, 1,  1, 0, 0, 0, 0, 0, 1,
                             ttc_pkg::ACT_NONE, 1));
    dir_table.push_back(drow(ttc_pkg::KIND_CONTACT, 1,  1, 0, 2621, 0, 100, 0, 1,
                             ttc_pkg::ACT_NONE, 1));
    dir_table.push_back(drow(ttc_pkg::KIND_END,     0,  0, 0, 0, 0, 280000, 0, 1,
                             ttc_pkg::ACT_LEFT, 0));
    // Largest slot and position, with the time wrapping round.
    dir_table.push_back(drow(ttc_pkg::KIND_CONTACT, 1,  1, 15, 65535, 65535, 32'hFFFF_FFF0,
                             0, 1, ttc_pkg::ACT_NONE, 1));
    dir_table.push_back(drow(ttc_pkg::KIND_END,     0,  0, 0, 0, 0, 32'h10, 0, 1,
                             ttc_pkg::ACT_RIGHT, 0));
    // Three touches in one frame.
    dir_table.push_back(drow(ttc_pkg::KIND_CONTACT, 1,  3, 0, 100, 200, 50, 0, 1,
                             ttc_pkg::ACT_NONE, 1));
    dir_table.push_back(drow(ttc_pkg::KIND_CONTACT, 0,  3, 1, 300, 400, 50, 0, 1,
                             ttc_pkg::ACT_NONE, 1));
    dir_table.push_back(drow(ttc_pkg::KIND_CONTACT, 0,  3, 2, 500, 600, 50, 0, 1,
                             ttc_pkg::ACT_NONE, 1));
    dir_table.push_back(drow(ttc_pkg::KIND_END,     0,  0, 0, 0, 0, 900, 0, 1,
                             ttc_pkg::ACT_MIDDLE, 0));
    // Two touches give no click.
    dir_table.push_back(drow(ttc_pkg::KIND_CONTACT, 1,  2, 4, 1000, 1000, 0, 0, 0,
                             ttc_pkg::ACT_NONE, 0));
    dir_table.push_back(drow(ttc_pkg::KIND_END,     0,  0, 0, 0, 0, 10, 0, 1,
                             ttc_pkg::ACT_NONE, 0));
    // Saturated count, largest identifier and a conflicting gesture.
    dir_table.push_back(drow(ttc_pkg::KIND_CONTACT, 1, 15, 32'hFFFF_FFFF, 0, 0, 0, 1, 1,
                             ttc_pkg::ACT_NONE, 1));
    dir_table.push_back(drow(ttc_pkg::KIND_END,     0,  0, 0, 0, 0, 0, 0, 1,
                             ttc_pkg::ACT_NONE, 0));
    // Movement just beyond the limit.
    dir_table.push_back(drow(ttc_pkg::KIND_CONTACT, 1,  1, 5, 0, 0, 0, 0, 1,
                             ttc_pkg::ACT_NONE, 1));
    dir_table.push_back(drow(ttc_pkg::KIND_CONTACT, 1,  1, 5, 2622, 0, 10, 0, 1,
                             ttc_pkg::ACT_NONE, 1));
    dir_table.push_back(drow(ttc_pkg::KIND_END,     0,  0, 0, 0, 0, 20, 0, 1,
                             ttc_pkg::ACT_NONE, 0));
    // Release one microsecond too late.
    dir_table.push_back(drow(ttc_pkg::KIND_CONTACT, 1,  1, 6, 0, 0, 0, 0, 1,
                             ttc_pkg::ACT_NONE, 1));
    dir_table.push_back(drow(ttc_pkg::KIND_END,     0,  0, 0, 0, 0, 280001, 0, 1,
                             ttc_pkg::ACT_NONE, 0));
    // Contact with a zero count, then an invalidate while tracking.
    dir_table.push_back(drow(ttc_pkg::KIND_CONTACT, 1,  0, 7, 0, 0, 0, 0, 1,
                             ttc_pkg::ACT_NONE, 1));
    dir_table.push_back(drow(ttc_pkg::KIND_INVAL,   0,  0, 0, 0, 0, 0, 0, 1,
                             ttc_pkg::ACT_NONE, 1));
    dir_table.push_back(drow(ttc_pkg::KIND_END,     0,  0, 0, 0, 0, 0, 0, 1,
                             ttc_pkg::ACT_NONE, 0));
    // A gesture started by a contact that is not first of its frame, then cleared.
    dir_table.push_back(drow(ttc_pkg::KIND_CONTACT, 0,  1, 16, 0, 0, 0, 0, 1,
                             ttc_pkg::ACT_NONE, 1));
    dir_table.push_back(drow(ttc_pkg::KIND_CLEAR,   0,  0, 0, 0, 0, 0, 0, 1,
                             ttc_pkg::ACT_NONE, 0));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_table[i]) send_item(dir_table[i].item, dir_table[i].typed, dir_table[i].res);

    // Random phases: settings from reset, the extremes and random values.
    run_phase(ttc_pkg::RST_MAX_DUR, 32'(ttc_pkg::RST_MAX_MOVE), 32'(ttc_pkg::RST_SPLIT_X),
              0, 0, 0, 0);
    run_phase(ttc_pkg::RST_MAX_DUR, 32'(ttc_pkg::RST_MAX_MOVE), 32'(ttc_pkg::RST_SPLIT_X),
              62, 0, 0, 0);
    run_phase(32'd0, 32'd0, 32'd0, 0, 62, 1, 0);
    run_phase(32'hFFFF_FFFF, 32'd65535, 32'd65535, 7, 7, 0, 0);
    run_phase($urandom_range(1000, 500000), $urandom_range(0, 8000), $urandom_range(0, 65535),
              62, 0, 0, 1);
    run_phase($urandom, $urandom, $urandom, 0, 62, 0, 0);
    run_phase($urandom_range(0, 2000000), $urandom_range(0, 65535), $urandom_range(0, 65535),
              7, 7, 0, 0);
    run_phase(ttc_pkg::RST_MAX_DUR, 32'(ttc_pkg::RST_MAX_MOVE), 32'(ttc_pkg::RST_SPLIT_X),
              0, 0, 0, 0);

    drain_results();
    repeat (8) @(negedge clk);
    if (error_count == 0) begin
      $display("touch_tap_click_recognizer_core: match");
    end else begin
      $display("touch_tap_click_recognizer_core: mismatch");
    end
    $finish;
  end

endmodule
